>>> rtl/sic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sic_pkg;

    localparam int COORD_BITS = 24;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int AREA_BITS  = PROD_BITS + 1;
    localparam int LIM_BITS   = 2 * COORD_BITS;
    localparam int SHIFT_BITS = 6;
    localparam int CODE_BITS  = 7;
    localparam int CLASS_BITS = 3;
    localparam int N_TRI      = 4;
    localparam int N_COORD    = 8;
    localparam int N_CODES    = 81;

    localparam int FIFO_DEPTH = 8;
    localparam int QPTR_BITS  = $clog2(FIFO_DEPTH);
    localparam int QCNT_BITS  = $clog2(FIFO_DEPTH + 1);

    localparam logic [SHIFT_BITS-1:0] TOL_SHIFT_RESET = SHIFT_BITS'(50);

    localparam logic [CLASS_BITS-1:0] CLS_NONE       = 3'd0;
    localparam logic [CLASS_BITS-1:0] CLS_CROSS      = 3'd1;
    localparam logic [CLASS_BITS-1:0] CLS_T_BD       = 3'd2;
    localparam logic [CLASS_BITS-1:0] CLS_T_AC       = 3'd3;
    localparam logic [CLASS_BITS-1:0] CLS_SHARED_END = 3'd4;
    localparam logic [CLASS_BITS-1:0] CLS_COINCIDENT = 3'd5;
    localparam logic [CLASS_BITS-1:0] CLS_COLLINEAR  = 3'd6;
    localparam logic [CLASS_BITS-1:0] CLS_IMPOSSIBLE = 3'd7;

    // row = (sA+1)*3+(sC+1), column = (sB+1)*3+(sD+1)
    localparam logic [CLASS_BITS-1:0] CLASS_TAB [N_CODES] = '{
        3'd1, 3'd2, 3'd0, 3'd2, 3'd7, 3'd7, 3'd0, 3'd7, 3'd7,
        3'd3, 3'd4, 3'd0, 3'd4, 3'd7, 3'd7, 3'd0, 3'd7, 3'd7,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd3, 3'd4, 3'd0, 3'd4, 3'd7, 3'd7, 3'd0, 3'd7, 3'd7,
        3'd7, 3'd7, 3'd5, 3'd7, 3'd6, 3'd7, 3'd5, 3'd7, 3'd7,
        3'd7, 3'd7, 3'd0, 3'd7, 3'd7, 3'd4, 3'd0, 3'd4, 3'd3,
        3'd0, 3'd0, 3'd0, 3'd0, 3'd5, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd7, 3'd7, 3'd0, 3'd7, 3'd7, 3'd4, 3'd0, 3'd4, 3'd3,
        3'd7, 3'd7, 3'd0, 3'd7, 3'd7, 3'd2, 3'd0, 3'd2, 3'd1
    };

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [AREA_BITS-1:0]  area_t;
    typedef logic [COORD_BITS-1:0]        cmag_t;
    typedef logic [AREA_BITS-1:0]         amag_t;
    typedef logic [LIM_BITS-1:0]          lim_t;

    typedef struct packed {
        logic [CODE_BITS-1:0]  code;
        logic [CLASS_BITS-1:0] cls;
        amag_t                 maxarea;
        lim_t                  lim;
    } mid_word_t;

    typedef struct packed {
        logic      valid;
        mid_word_t word;
    } mid_item_t;

endpackage
`default_nettype wire

>>> rtl/segment_intersection_classifier.sv
// path to the result side: stage 1 loads at the push edge, then 3 more front stages,
// a queue write and the output register; a stall at the output holds words in the queue
// throughput: one word per cycle while full is low; an 8-entry queue between front and back absorbs stalls
// full rises once 8 words sit in the front stages and queue together
// reset: asynchronous, active low; empties everything and sets tolerance_shift to 50
`timescale 1ns / 1ps
`default_nettype none
module segment_intersection_classifier (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  sic_pkg::coord_t                ax,
    input  sic_pkg::coord_t                ay,
    input  sic_pkg::coord_t                cx,
    input  sic_pkg::coord_t                cy,
    input  sic_pkg::coord_t                bx,
    input  sic_pkg::coord_t                by,
    input  sic_pkg::coord_t                dx,
    input  sic_pkg::coord_t                dy,
    output logic                           empty,
    input  logic                           pop,
    output logic [sic_pkg::CLASS_BITS-1:0] int_class,
    output logic [sic_pkg::CODE_BITS-1:0]  sign_code,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sic_pkg::SHIFT_BITS-1:0] tolerance_shift
);
    import sic_pkg::*;

    mid_item_t mid;
    mid_item_t head;
    logic      q_rd;

    sic_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .ax    (ax),
        .ay    (ay),
        .cx    (cx),
        .cy    (cy),
        .bx    (bx),
        .by    (by),
        .dx    (dx),
        .dy    (dy),
        .q_rd  (q_rd),
        .mid   (mid)
    );

    sic_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (mid),
        .rd    (q_rd),
        .head  (head)
    );

    sic_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .q_rd            (q_rd),
        .empty           (empty),
        .pop             (pop),
        .int_class       (int_class),
        .sign_code       (sign_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .tolerance_shift (tolerance_shift)
    );

endmodule
`default_nettype wire

>>> rtl/sic_front.sv
`timescale 1ns / 1ps
`default_nettype none
module sic_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  sic_pkg::coord_t   ax,
    input  sic_pkg::coord_t   ay,
    input  sic_pkg::coord_t   cx,
    input  sic_pkg::coord_t   cy,
    input  sic_pkg::coord_t   bx,
    input  sic_pkg::coord_t   by,
    input  sic_pkg::coord_t   dx,
    input  sic_pkg::coord_t   dy,
    input  logic              q_rd,
    output sic_pkg::mid_item_t mid
);
    import sic_pkg::*;

    function automatic diff_t sub_c(input coord_t p, input coord_t q);
        return diff_t'(p) - diff_t'(q);
    endfunction

    function automatic cmag_t abs_c(input coord_t v);
        return v[COORD_BITS-1] ? cmag_t'(-v) : cmag_t'(v);
    endfunction

    function automatic cmag_t max_c(input cmag_t p, input cmag_t q);
        return (p > q) ? p : q;
    endfunction

    function automatic amag_t max_a(input amag_t p, input amag_t q);
        return (p > q) ? p : q;
    endfunction

    logic                 in_acc;
    logic [QCNT_BITS-1:0] occ_reg;
    logic [QCNT_BITS-1:0] occ_next;

    // credit count: words in the pipe plus words in the queue
    assign full   = (occ_reg == QCNT_BITS'(FIFO_DEPTH));
    assign in_acc = push && !full;

    always_comb
    begin
        case ({in_acc, q_rd})
            2'b10:   occ_next = occ_reg + QCNT_BITS'(1);
            2'b01:   occ_next = occ_reg - QCNT_BITS'(1);
            default: occ_next = occ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // stage 1: edge vectors and coordinate magnitudes
    // triangles: 0 = bcd, 1 = cda, 2 = dab, 3 = abc
    diff_t ux_next [N_TRI];
    diff_t uy_next [N_TRI];
    diff_t vx_next [N_TRI];
    diff_t vy_next [N_TRI];
    cmag_t cm_next [N_COORD];

    always_comb
    begin
        ux_next[0] = sub_c(cx, bx); uy_next[0] = sub_c(cy, by);
        vx_next[0] = sub_c(dx, bx); vy_next[0] = sub_c(dy, by);
        ux_next[1] = sub_c(dx, cx); uy_next[1] = sub_c(dy, cy);
        vx_next[1] = sub_c(ax, cx); vy_next[1] = sub_c(ay, cy);
        ux_next[2] = sub_c(ax, dx); uy_next[2] = sub_c(ay, dy);
        vx_next[2] = sub_c(bx, dx); vy_next[2] = sub_c(by, dy);
        ux_next[3] = sub_c(bx, ax); uy_next[3] = sub_c(by, ay);
        vx_next[3] = sub_c(cx, ax); vy_next[3] = sub_c(cy, ay);
        cm_next[0] = abs_c(ax); cm_next[1] = abs_c(ay);
        cm_next[2] = abs_c(cx); cm_next[3] = abs_c(cy);
        cm_next[4] = abs_c(bx); cm_next[5] = abs_c(by);
        cm_next[6] = abs_c(dx); cm_next[7] = abs_c(dy);
    end

    logic  s1_valid_reg;
    diff_t s1_ux_reg [N_TRI];
    diff_t s1_uy_reg [N_TRI];
    diff_t s1_vx_reg [N_TRI];
    diff_t s1_vy_reg [N_TRI];
    cmag_t s1_cm_reg [N_COORD];

    always_ff @(posedge clk)
    begin
        s1_ux_reg <= ux_next;
        s1_uy_reg <= uy_next;
        s1_vx_reg <= vx_next;
        s1_vy_reg <= vy_next;
        s1_cm_reg <= cm_next;
    end

    // stage 2: cross products and largest coordinate magnitude
    prod_t p1_next [N_TRI];
    prod_t p2_next [N_TRI];
    cmag_t cm_l1 [4];
    cmag_t cm_l2 [2];
    cmag_t maxc_next;

    always_comb
    begin
        for (int i = 0; i < N_TRI; i++)
        begin
            p1_next[i] = prod_t'(s1_ux_reg[i]) * prod_t'(s1_vy_reg[i]);
            p2_next[i] = prod_t'(s1_uy_reg[i]) * prod_t'(s1_vx_reg[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            cm_l1[i] = max_c(s1_cm_reg[2*i], s1_cm_reg[2*i+1]);
        end
        for (int i = 0; i < 2; i++)
        begin
            cm_l2[i] = max_c(cm_l1[2*i], cm_l1[2*i+1]);
        end
        maxc_next = max_c(cm_l2[0], cm_l2[1]);
    end

    logic  s2_valid_reg;
    prod_t s2_p1_reg [N_TRI];
    prod_t s2_p2_reg [N_TRI];
    cmag_t s2_maxc_reg;

    always_ff @(posedge clk)
    begin
        s2_p1_reg   <= p1_next;
        s2_p2_reg   <= p2_next;
        s2_maxc_reg <= maxc_next;
    end

    // stage 3: doubled areas and tolerance limit
    area_t area_next [N_TRI];
    lim_t  sq_next;

    always_comb
    begin
        for (int i = 0; i < N_TRI; i++)
        begin
            area_next[i] = area_t'(s2_p1_reg[i]) - area_t'(s2_p2_reg[i]);
        end
        sq_next = lim_t'(s2_maxc_reg) * lim_t'(s2_maxc_reg);
    end

    logic  s3_valid_reg;
    area_t s3_area_reg [N_TRI];
    lim_t  s3_lim_reg;

    always_ff @(posedge clk)
    begin
        s3_area_reg <= area_next;
        s3_lim_reg  <= sq_next << 1;
    end

    // stage 4: signs, table index, class, area magnitudes
    logic [1:0]            t_sgn [N_TRI];
    amag_t                 amag [N_TRI];
    logic [CODE_BITS-1:0]  code_next;
    logic [CLASS_BITS-1:0] cls_next;

    always_comb
    begin
        for (int i = 0; i < N_TRI; i++)
        begin
            if (s3_area_reg[i] == '0)
            begin
                t_sgn[i] = 2'd1;
            end
            else if (s3_area_reg[i][AREA_BITS-1])
            begin
                t_sgn[i] = 2'd0;
            end
            else
            begin
                t_sgn[i] = 2'd2;
            end
            amag[i] = s3_area_reg[i][AREA_BITS-1] ? amag_t'(-s3_area_reg[i])
                                                   : amag_t'(s3_area_reg[i]);
        end
        code_next = CODE_BITS'(27 * t_sgn[0] + 9 * t_sgn[2] + 3 * t_sgn[1] + t_sgn[3]);
        cls_next  = CLASS_TAB[code_next];
    end

    logic                  s4_valid_reg;
    logic [CODE_BITS-1:0]  s4_code_reg;
    logic [CLASS_BITS-1:0] s4_cls_reg;
    amag_t                 s4_mab_reg;
    amag_t                 s4_mcd_reg;
    lim_t                  s4_lim_reg;

    always_ff @(posedge clk)
    begin
        s4_code_reg <= code_next;
        s4_cls_reg  <= cls_next;
        s4_mab_reg  <= max_a(amag[0], amag[1]);
        s4_mcd_reg  <= max_a(amag[2], amag[3]);
        s4_lim_reg  <= s3_lim_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_acc;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_comb
    begin
        mid.valid        = s4_valid_reg;
        mid.word.code    = s4_code_reg;
        mid.word.cls     = s4_cls_reg;
        mid.word.maxarea = max_a(s4_mab_reg, s4_mcd_reg);
        mid.word.lim     = s4_lim_reg;
    end

endmodule
`default_nettype wire

>>> rtl/sic_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module sic_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  sic_pkg::mid_item_t wr,
    input  logic               rd,
    output sic_pkg::mid_item_t head
);
    import sic_pkg::*;

    mid_word_t            mem [FIFO_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg;
    logic [QPTR_BITS-1:0] wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_next;
    logic [QCNT_BITS-1:0] cnt_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (wr.valid)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_BITS'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
        end
        case ({wr.valid, rd})
            2'b10:   cnt_next = cnt_reg + QCNT_BITS'(1);
            2'b01:   cnt_next = cnt_reg - QCNT_BITS'(1);
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            mem[wr_ptr_reg] <= wr.word;
        end
    end

    assign head.valid = (cnt_reg != '0);
    assign head.word  = mem[rd_ptr_reg];

endmodule
`default_nettype wire

>>> rtl/sic_back.sv
`timescale 1ns / 1ps
`default_nettype none
module sic_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sic_pkg::mid_item_t               head,
    output logic                             q_rd,
    output logic                             empty,
    input  logic                             pop,
    output logic [sic_pkg::CLASS_BITS-1:0]   int_class,
    output logic [sic_pkg::CODE_BITS-1:0]    sign_code,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [sic_pkg::SHIFT_BITS-1:0]   tolerance_shift
);
    import sic_pkg::*;

    logic [SHIFT_BITS-1:0] tol_reg;
    logic                  out_valid_reg;
    logic [CLASS_BITS-1:0] cls_reg;
    logic [CODE_BITS-1:0]  code_reg;
    logic [CLASS_BITS-1:0] cls_next;
    lim_t                  thr;
    logic                  negligible;

    assign cfg_ready = 1'b1;
    assign q_rd      = head.valid && (!out_valid_reg || pop);

    // impossible pattern with areas tiny against the coordinates reads as collinear
    always_comb
    begin
        thr        = (head.word.lim - lim_t'(1)) >> tol_reg;
        negligible = (head.word.lim != '0) && (head.word.maxarea <= AREA_BITS'(thr));
        if (head.word.cls == CLS_IMPOSSIBLE && negligible)
        begin
            cls_next = CLS_COLLINEAR;
        end
        else
        begin
            cls_next = head.word.cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg       <= TOL_SHIFT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                tol_reg <= tolerance_shift;
            end
            if (q_rd)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_rd)
        begin
            cls_reg  <= cls_next;
            code_reg <= head.word.code;
        end
    end

    assign empty     = !out_valid_reg;
    assign int_class = cls_reg;
    assign sign_code = code_reg;

endmodule
`default_nettype wire

>>> rtl/sic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sic_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [sic_pkg::CLASS_BITS-1:0] int_class,
    input logic [sic_pkg::CODE_BITS-1:0]  sign_code
);
    import sic_pkg::*;

    // waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(int_class) && $stable(sign_code))
        else $error("result word changed while stalled");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> sign_code <= CODE_BITS'(N_CODES - 1))
        else $error("sign_code out of range");

    // class follows the table, except the impossible to collinear override
    a_class: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && sign_code <= CODE_BITS'(N_CODES - 1) |->
            int_class == CLASS_TAB[sign_code] ||
            (int_class == CLS_COLLINEAR && CLASS_TAB[sign_code] == CLS_IMPOSSIBLE))
        else $error("int_class does not match sign_code");

    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> empty && !full)
        else $error("not empty after reset");

endmodule

bind segment_intersection_classifier sic_checker u_sic_checker (.*);
`default_nettype wire

>>> dv/segment_intersection_classifier_tb.sv
`timescale 1ns / 1ps
module segment_intersection_classifier_tb;
    import sic_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int RESET_CYCLES = 12;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 20;
    localparam int TIMEOUT_NS = 5_000_000;
    localparam int MAX_REPORTS = 10;
    localparam logic [SHIFT_BITS-1:0] TOL_AT_RESET = 6'd50;
    localparam logic [SHIFT_BITS-1:0] TOL_LOWEST = 6'd0;
    localparam logic [SHIFT_BITS-1:0] TOL_HIGHEST = 6'd63;
    localparam int CMAX = 8388607;
    localparam int CMIN = -8388608;

    localparam int AX = 0;
    localparam int AY = 1;
    localparam int CX = 2;
    localparam int CY = 3;
    localparam int BX = 4;
    localparam int BY = 5;
    localparam int DX = 6;
    localparam int DY = 7;

    localparam logic [CLASS_BITS-1:0] NO = CLS_NONE;
    localparam logic [CLASS_BITS-1:0] CR = CLS_CROSS;
    localparam logic [CLASS_BITS-1:0] TB = CLS_T_BD;
    localparam logic [CLASS_BITS-1:0] TA = CLS_T_AC;
    localparam logic [CLASS_BITS-1:0] SE = CLS_SHARED_END;
    localparam logic [CLASS_BITS-1:0] CO = CLS_COINCIDENT;
    localparam logic [CLASS_BITS-1:0] CL = CLS_COLLINEAR;
    localparam logic [CLASS_BITS-1:0] IM = CLS_IMPOSSIBLE;

    // row from signs of A and C, column from signs of B and D
    localparam logic [CLASS_BITS-1:0] SIGN_CLASS [N_CODES] = '{
        CR, TB, NO, TB, IM, IM, NO, IM, IM,
        TA, SE, NO, SE, IM, IM, NO, IM, IM,
        NO, NO, NO, NO, CO, NO, NO, NO, NO,
        TA, SE, NO, SE, IM, IM, NO, IM, IM,
        IM, IM, CO, IM, CL, IM, CO, IM, IM,
        IM, IM, NO, IM, IM, SE, NO, SE, TA,
        NO, NO, NO, NO, CO, NO, NO, NO, NO,
        IM, IM, NO, IM, IM, SE, NO, SE, TA,
        IM, IM, NO, IM, IM, TB, NO, TB, CR
    };

    typedef logic [N_COORD-1:0][COORD_BITS-1:0] pts_t;

    typedef struct packed {
        logic [CLASS_BITS-1:0] cls;
        logic [CODE_BITS-1:0]  code;
    } verdict_t;

    typedef enum int {
        GEN_UNIFORM,
        GEN_TINY,
        GEN_SHARED,
        GEN_COLLINEAR,
        GEN_TOUCH,
        GEN_EXTREME
    } gen_mode_e;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    coord_t ax = '0;
    coord_t ay = '0;
    coord_t cx = '0;
    coord_t cy = '0;
    coord_t bx = '0;
    coord_t by = '0;
    coord_t dx = '0;
    coord_t dy = '0;
    logic empty;
    logic pop = 1'b0;
    logic [CLASS_BITS-1:0] int_class;
    logic [CODE_BITS-1:0] sign_code;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [SHIFT_BITS-1:0] tolerance_shift = '0;

    verdict_t pending_verdicts [$];
    logic [SHIFT_BITS-1:0] tol_shift_model = TOL_AT_RESET;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int err_count = 0;

    segment_intersection_classifier DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .ax              (ax),
        .ay              (ay),
        .cx              (cx),
        .cy              (cy),
        .bx              (bx),
        .by              (by),
        .dx              (dx),
        .dy              (dy),
        .empty           (empty),
        .pop             (pop),
        .int_class       (int_class),
        .sign_code       (sign_code),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .tolerance_shift (tolerance_shift)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint tri_area(longint px, longint py, longint qx, longint qy,
                                        longint rx, longint ry);
        return (qx - px) * (ry - py) - (qy - py) * (rx - px);
    endfunction

    function automatic int sgn3(longint v);
        if (v > 0)
            return 1;
        if (v < 0)
            return -1;
        return 0;
    endfunction

    function automatic bit [63:0] mag64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic verdict_t classify_pair(pts_t p, logic [SHIFT_BITS-1:0] shift);
        longint xa, ya, xc, yc, xb, yb, xd, yd;
        longint area_a, area_b, area_c, area_d;
        bit [63:0] max_area;
        bit [63:0] max_coord;
        bit [63:0] lim;
        int code;
        verdict_t v;
        xa = $signed(p[AX]);
        ya = $signed(p[AY]);
        xc = $signed(p[CX]);
        yc = $signed(p[CY]);
        xb = $signed(p[BX]);
        yb = $signed(p[BY]);
        xd = $signed(p[DX]);
        yd = $signed(p[DY]);
        area_a = tri_area(xb, yb, xc, yc, xd, yd);
        area_b = tri_area(xc, yc, xd, yd, xa, ya);
        area_c = tri_area(xd, yd, xa, ya, xb, yb);
        area_d = tri_area(xa, ya, xb, yb, xc, yc);
        code = 27 * sgn3(area_a) + 9 * sgn3(area_c) + 3 * sgn3(area_b) + sgn3(area_d) + 40;
        v.code = code[CODE_BITS-1:0];
        v.cls = SIGN_CLASS[code];
        if (v.cls == IM)
        begin
            max_area = mag64(area_a);
            if (mag64(area_b) > max_area)
                max_area = mag64(area_b);
            if (mag64(area_c) > max_area)
                max_area = mag64(area_c);
            if (mag64(area_d) > max_area)
                max_area = mag64(area_d);
            max_coord = 0;
            for (int i = 0; i < N_COORD; i++)
                if (mag64($signed(p[i])) > max_coord)
                    max_coord = mag64($signed(p[i]));
            lim = 2 * max_coord * max_coord;
            if (lim != 0 && max_area <= ((lim - 1) >> shift))
                v.cls = CL;
        end
        return v;
    endfunction

    function automatic pts_t pack_pts(int xa, int ya, int xc, int yc,
                                      int xb, int yb, int xd, int yd);
        pts_t p;
        p[AX] = COORD_BITS'(xa);
        p[AY] = COORD_BITS'(ya);
        p[CX] = COORD_BITS'(xc);
        p[CY] = COORD_BITS'(yc);
        p[BX] = COORD_BITS'(xb);
        p[BY] = COORD_BITS'(yb);
        p[DX] = COORD_BITS'(xd);
        p[DY] = COORD_BITS'(yd);
        return p;
    endfunction

    function automatic int rand_span(int half);
        int t;
        t = $urandom_range(0, 2 * half);
        return t - half;
    endfunction

    function automatic pts_t random_pair();
        pts_t p;
        gen_mode_e mode;
        int pick;
        int base_x, base_y, step_x, step_y, m, kb;
        pick = $urandom_range(0, 99);
        if (pick < 20)
            mode = GEN_UNIFORM;
        else if (pick < 38)
            mode = GEN_TINY;
        else if (pick < 53)
            mode = GEN_SHARED;
        else if (pick < 73)
            mode = GEN_COLLINEAR;
        else if (pick < 90)
            mode = GEN_TOUCH;
        else
            mode = GEN_EXTREME;
        for (int i = 0; i < N_COORD; i++)
            p[i] = COORD_BITS'($urandom());
        base_x = rand_span(1 << 20);
        base_y = rand_span(1 << 20);
        step_x = rand_span(1 << 10);
        step_y = rand_span(1 << 10);
        case (mode)
            GEN_TINY:
                for (int i = 0; i < N_COORD; i++)
                    p[i] = COORD_BITS'(rand_span(4));
            GEN_SHARED:
            begin
                if ($urandom_range(0, 1))
                    for (int i = 0; i < N_COORD; i++)
                        p[i] = COORD_BITS'(rand_span(1 << 12));
                case ($urandom_range(0, 3))
                    0: begin p[BX] = p[AX]; p[BY] = p[AY]; end
                    1: begin p[DX] = p[AX]; p[DY] = p[AY]; end
                    2: begin p[BX] = p[CX]; p[BY] = p[CY]; end
                    default: begin p[DX] = p[CX]; p[DY] = p[CY]; end
                endcase
            end
            GEN_COLLINEAR:
                for (int i = 0; i < N_COORD; i += 2)
                begin
                    m = rand_span(64);
                    p[i] = COORD_BITS'(base_x + m * step_x);
                    p[i + 1] = COORD_BITS'(base_y + m * step_y);
                end
            GEN_TOUCH:
            begin
                m = $urandom_range(1, 64);
                kb = $urandom_range(0, m);
                p[AX] = COORD_BITS'(base_x);
                p[AY] = COORD_BITS'(base_y);
                p[CX] = COORD_BITS'(base_x + m * step_x);
                p[CY] = COORD_BITS'(base_y + m * step_y);
                p[BX] = COORD_BITS'(base_x + kb * step_x);
                p[BY] = COORD_BITS'(base_y + kb * step_y);
                p[DX] = COORD_BITS'(base_x + kb * step_x + rand_span(1 << 10));
                p[DY] = COORD_BITS'(base_y + kb * step_y + rand_span(1 << 10));
                if ($urandom_range(0, 1))
                    p = pack_pts($signed(p[BX]), $signed(p[BY]), $signed(p[DX]),
                                 $signed(p[DY]), $signed(p[AX]), $signed(p[AY]),
                                 $signed(p[CX]), $signed(p[CY]));
            end
            GEN_EXTREME:
                for (int i = 0; i < N_COORD; i++)
                    case ($urandom_range(0, 5))
                        0: p[i] = COORD_BITS'(CMIN);
                        1: p[i] = COORD_BITS'(CMAX);
                        2: p[i] = '0;
                        3: p[i] = '1;
                        4: p[i] = COORD_BITS'(1);
                        default: ;
                    endcase
            default: ;
        endcase
        return p;
    endfunction

    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic send_word(input pts_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        ax <= p[AX];
        ay <= p[AY];
        cx <= p[CX];
        cy <= p[CY];
        bx <= p[BX];
        by <= p[BY];
        dx <= p[DX];
        dy <= p[DY];
        do
            @(posedge clk);
        while (full);
        pending_verdicts.push_back(classify_pair(p, tol_shift_model));
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_tolerance(input logic [SHIFT_BITS-1:0] shift);
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        tolerance_shift <= shift;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tol_shift_model = shift;
    endtask

    task automatic run_random_words(input int n_words, input logic [SHIFT_BITS-1:0] shift);
        write_tolerance(shift);
        repeat (n_words) send_word(random_pair());
    endtask

    task automatic test_directed_cases();
        send_idle_pct = 13;
        recv_idle_pct = 60;
        send_word(pack_pts(0, 0, 0, 0, 0, 0, 0, 0));
        send_word(pack_pts(0, 0, 2, 0, 1, -1, 1, 1));
        send_word(pack_pts(0, 0, 2, 0, 1, 1, 1, -1));
        send_word(pack_pts(0, 0, 2, 0, 1, 0, 1, 1));
        send_word(pack_pts(0, 0, 2, 0, 1, 1, 1, 0));
        send_word(pack_pts(1, 0, 1, 5, 0, 0, 2, 0));
        send_word(pack_pts(0, 0, 2, 0, 0, 0, 0, 3));
        send_word(pack_pts(0, 0, 2, 0, 4, 4, 2, 0));
        send_word(pack_pts(1, 1, 5, 3, 1, 1, 5, 3));
        send_word(pack_pts(1, 1, 5, 3, 5, 3, 1, 1));
        send_word(pack_pts(0, 0, 1, 0, 2, 0, 3, 0));
        send_word(pack_pts(0, 0, 3, 0, 1, 0, 5, 0));
        send_word(pack_pts(0, 0, 4, 0, 0, 1, 4, 1));
        send_word(pack_pts(0, 0, 1, 1, 5, 0, 9, -3));
        send_word(pack_pts(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        send_word(pack_pts(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        send_word(pack_pts(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        send_word(pack_pts(CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN));
        send_word(pack_pts(3, 3, 3, 3, 0, 0, 5, 5));
        send_word(pack_pts(3, 3, 3, 3, 7, -2, 7, -2));
        send_word(pack_pts(24'h555555, 24'haaaaaa, 24'haaaaaa, 24'h555555,
                           24'h555555, 24'h555555, 24'haaaaaa, 24'haaaaaa));
        send_word(pack_pts(CMIN, CMIN, CMAX, CMAX, -1, -1, 1, 1));
        send_word(pack_pts(CMIN, 0, CMAX, 0, 0, CMIN, 0, CMAX));
        send_word(pack_pts(-1, -1, 1, 1, -1, 1, 1, -1));
    endtask

    task automatic test_tolerance_extremes();
        send_idle_pct = 13;
        recv_idle_pct = 60;
        run_random_words(40, TOL_LOWEST);
        run_random_words(40, TOL_HIGHEST);
    endtask

    task automatic test_sender_light_idle();
        send_idle_pct = 13;
        recv_idle_pct = 60;
        run_random_words(250, SHIFT_BITS'($urandom_range(0, 63)));
    endtask

    task automatic test_receiver_light_idle();
        send_idle_pct = 60;
        recv_idle_pct = 13;
        run_random_words(250, TOL_AT_RESET);
    endtask

    task automatic test_no_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_words(250, SHIFT_BITS'($urandom_range(0, 63)));
    endtask

    always @(posedge clk)
    begin : pop_side
        verdict_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_verdicts.size() == 0)
                flag_error("word popped with no prediction pending");
            else
            begin
                want = pending_verdicts.pop_front();
                if (int_class !== want.cls || sign_code !== want.code)
                    flag_error($sformatf("int_class/sign_code expected %0d/%0d got %0d/%0d",
                                         want.cls, want.code, int_class, sign_code));
            end
        end
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_tolerance_extremes();
        test_sender_light_idle();
        test_receiver_light_idle();
        test_no_idle();
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && pending_verdicts.size() == 0)
            $display("segment_intersection_classifier: match");
        else
            $display("segment_intersection_classifier: mismatch");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("segment_intersection_classifier: mismatch");
        $finish;
    end

endmodule

>>> filelist.f
rtl/sic_pkg.sv
rtl/sic_front.sv
rtl/sic_queue.sv
rtl/sic_back.sv
rtl/segment_intersection_classifier.sv
rtl/sic_checker.sv
dv/segment_intersection_classifier_tb.sv
